/* sv/alp_pkg.sv */
// Package with shared constants, types and codes of the address lease pool.
package alp_pkg;

  localparam int POOL_SIZE = 256;
  localparam int IDX_W = $clog2(POOL_SIZE);
  localparam int CNT_W = $clog2(POOL_SIZE + 1);
  localparam int ADDR_W = 32;
  localparam int MAC_W = 48;
  localparam int COUNT_W = 9;
  localparam int LEASE_W = 31;
  localparam int CFG_IDX_W = 2;

  localparam logic [ADDR_W-1:0] POOL_BASE_RST = 32'd0;
  localparam logic [COUNT_W-1:0] POOL_COUNT_RST = 9'd256;
  localparam logic [ADDR_W-1:0] SERVER_ADDRESS_RST = 32'd0;
  localparam logic [LEASE_W-1:0] LEASE_SECONDS_RST = 31'd86400;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_BASE      = 2'd0,
    CFG_POOL_COUNT     = 2'd1,
    CFG_SERVER_ADDRESS = 2'd2,
    CFG_LEASE_SECONDS  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ACT_DISCOVER = 2'd0,
    ACT_REQUEST  = 2'd1,
    ACT_RELEASE  = 2'd2,
    ACT_TICK     = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_REFUSED = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_DONE    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISC,
    ST_TICK,
    ST_REQ,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic              used;
    logic [MAC_W-1:0]  mac;
    logic [ADDR_W-1:0] expiry;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

/* sv/alp_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module alp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/address_lease_pool_top.sv */
// Top level of the address lease pool: control, configuration and the entry memory.
// Each pool entry (used mark, owner MAC, expiry) sits in one RAM word with a registered
// read, and the block handles one transaction at a time. After reset the block clears
// every one of the POOL_SIZE RAM entries before it takes its first item; configuration
// writes are taken at any time. A release writes its entry directly; a request does one
// RAM read, then the write-back. A discover reads the entries in order, one per cycle,
// up to the number of live pool entries. A tick reads every one of the POOL_SIZE entries.
// A finished result waits in an output register, so the next item is accepted while the
// previous result is still stalled.
module address_lease_pool_top import alp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ADDR_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           action_i,
  input  logic [ADDR_W-1:0]    address_i,
  input  logic [MAC_W-1:0]     client_mac_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           status_o,
  output logic [ADDR_W-1:0]    result_address_o
);

  state_e state_q, state_d;

  logic [ADDR_W-1:0]  pool_base_q;
  logic [COUNT_W-1:0] pool_count_q;
  logic [ADDR_W-1:0]  server_address_q;
  logic [LEASE_W-1:0] lease_seconds_q;
  logic [ADDR_W-1:0]  seconds_q, seconds_d;

  logic [CNT_W-1:0] scan_q, scan_d;
  logic             pend_q, pend_d;
  logic [IDX_W-1:0] pidx_q, pidx_d;

  logic [ADDR_W-1:0] req_addr_q, req_addr_d;
  logic [MAC_W-1:0]  req_mac_q, req_mac_d;
  status_e           res_status_q, res_status_d;
  logic [ADDR_W-1:0] res_addr_q, res_addr_d;

  logic              out_valid_q;
  status_e           out_status_q;
  logic [ADDR_W-1:0] out_addr_q;
  logic              out_load;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t           rd_entry;

  logic [ADDR_W-1:0] live_cnt;
  logic [ADDR_W-1:0] srv_off;
  logic [ADDR_W-1:0] in_off;
  logic              in_usable;
  logic [ADDR_W-1:0] scan_limit;
  logic [ADDR_W-1:0] left;
  logic              expired;
  logic              in_accept;

  alp_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(POOL_SIZE)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);

  assign live_cnt = (32'(pool_count_q) > 32'(POOL_SIZE)) ? 32'(POOL_SIZE)
                                                         : 32'(pool_count_q);
  assign srv_off = server_address_q - pool_base_q - 32'd1;
  assign in_off = address_i - pool_base_q - 32'd1;
  assign in_usable = (in_off < live_cnt) && (in_off != srv_off);
  assign scan_limit = (state_q == ST_DISC) ? live_cnt : 32'(POOL_SIZE);
  assign left = rd_entry.expiry - seconds_q;
  assign expired = (left == '0) || left[ADDR_W-1];

  assign cfg_ready_o = 1'b1;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    seconds_d = seconds_q;
    scan_d = scan_q;
    pend_d = pend_q;
    pidx_d = pidx_q;
    req_addr_d = req_addr_q;
    req_mac_d = req_mac_q;
    res_status_d = res_status_q;
    res_addr_d = res_addr_q;
    out_load = 1'b0;
    ram_we = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re = 1'b0;
    ram_raddr = '0;

    case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = scan_q[IDX_W-1:0];
        scan_d = scan_q + CNT_W'(1);
        if (scan_q == CNT_W'(POOL_SIZE - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          scan_d = '0;
          pend_d = 1'b0;
          res_addr_d = '0;
          case (action_e'(action_i))
            ACT_DISCOVER: begin
              state_d = ST_DISC;
            end
            ACT_REQUEST: begin
              req_addr_d = address_i;
              req_mac_d = client_mac_i;
              if (in_usable) begin
                ram_re = 1'b1;
                ram_raddr = in_off[IDX_W-1:0];
                pidx_d = in_off[IDX_W-1:0];
                state_d = ST_REQ;
              end else begin
                res_status_d = STAT_REFUSED;
                state_d = ST_RESULT;
              end
            end
            ACT_RELEASE: begin
              if (in_usable) begin
                ram_we = 1'b1;
                ram_waddr = in_off[IDX_W-1:0];
              end
              res_status_d = STAT_DONE;
              state_d = ST_RESULT;
            end
            ACT_TICK: begin
              seconds_d = seconds_q + 32'd1;
              state_d = ST_TICK;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_DISC, ST_TICK: begin
        if (32'(scan_q) < scan_limit) begin
          ram_re = 1'b1;
          ram_raddr = scan_q[IDX_W-1:0];
          pidx_d = scan_q[IDX_W-1:0];
          pend_d = 1'b1;
          scan_d = scan_q + CNT_W'(1);
        end else begin
          pend_d = 1'b0;
        end
        if (state_q == ST_DISC) begin
          if (pend_q && !rd_entry.used && (32'(pidx_q) != srv_off)) begin
            res_status_d = STAT_OK;
            res_addr_d = pool_base_q + 32'd1 + 32'(pidx_q);
            state_d = ST_RESULT;
          end else if (!pend_q && (32'(scan_q) >= scan_limit)) begin
            res_status_d = STAT_FULL;
            state_d = ST_RESULT;
          end
        end else begin
          if (pend_q && rd_entry.used && expired) begin
            ram_we = 1'b1;
            ram_waddr = pidx_q;
            ram_wdata = rd_entry;
            ram_wdata.used = 1'b0;
          end
          if (!pend_q && (32'(scan_q) >= scan_limit)) begin
            res_status_d = STAT_DONE;
            state_d = ST_RESULT;
          end
        end
      end
      ST_REQ: begin
        if (!rd_entry.used || (rd_entry.mac == req_mac_q)) begin
          ram_we = 1'b1;
          ram_waddr = pidx_q;
          ram_wdata.used = 1'b1;
          ram_wdata.mac = req_mac_q;
          ram_wdata.expiry = seconds_q + {1'b0, lease_seconds_q};
          res_status_d = STAT_OK;
          res_addr_d = req_addr_q;
        end else begin
          res_status_d = STAT_REFUSED;
        end
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      seconds_q <= '0;
      scan_q <= '0;
      pend_q <= 1'b0;
      out_valid_q <= 1'b0;
      pool_base_q <= POOL_BASE_RST;
      pool_count_q <= POOL_COUNT_RST;
      server_address_q <= SERVER_ADDRESS_RST;
      lease_seconds_q <= LEASE_SECONDS_RST;
    end else begin
      state_q <= state_d;
      seconds_q <= seconds_d;
      scan_q <= scan_d;
      pend_q <= pend_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_POOL_BASE:      pool_base_q <= cfg_data_i;
          CFG_POOL_COUNT:     pool_count_q <= cfg_data_i[COUNT_W-1:0];
          CFG_SERVER_ADDRESS: server_address_q <= cfg_data_i;
          CFG_LEASE_SECONDS:  lease_seconds_q <= cfg_data_i[LEASE_W-1:0];
          default: begin
            pool_base_q <= pool_base_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= pidx_d;
    req_addr_q <= req_addr_d;
    req_mac_q <= req_mac_d;
    res_status_q <= res_status_d;
    res_addr_q <= res_addr_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_addr_q <= res_addr_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o = out_status_q;
  assign result_address_o = out_addr_q;

endmodule

/* tb/address_lease_pool_top_tb.sv */
// Self-checking testbench of address_lease_pool_top with a lease pool predictor.
module address_lease_pool_top_tb;
  import alp_pkg::*;

  localparam int ITEM_TOTAL = 1100;
  localparam int QUIET_ITEMS = 80;
  localparam int HOLD_CYCLES = 600;
  localparam int HOLD_AT_ITEM = 300;
  localparam logic [MAC_W-1:0] MAC_ALL1 = {MAC_W{1'b1}};

  typedef struct packed {
    action_e           act;
    logic [ADDR_W-1:0] addr;
    logic [MAC_W-1:0]  mac;
  } lease_item_t;

  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] addr;
  } lease_result_t;

  typedef struct {
    bit            is_cfg;
    cfg_idx_e      reg_idx;
    logic [31:0]   reg_data;
    lease_item_t   item;
    bit            typed;
    lease_result_t want;
  } plan_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [ADDR_W-1:0]    cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [1:0]           action_i;
  logic [ADDR_W-1:0]    address_i;
  logic [MAC_W-1:0]     client_mac_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [1:0]           status_o;
  logic [ADDR_W-1:0]    result_address_o;

  // Predictor copy of the configuration and of the lease table.
  logic [ADDR_W-1:0]  base_reg = POOL_BASE_RST;
  logic [COUNT_W-1:0] count_reg = POOL_COUNT_RST;
  logic [ADDR_W-1:0]  server_reg = SERVER_ADDRESS_RST;
  logic [LEASE_W-1:0] lease_reg = LEASE_SECONDS_RST;
  bit                 slot_used [POOL_SIZE];
  logic [MAC_W-1:0]   slot_mac [POOL_SIZE];
  logic [ADDR_W-1:0]  slot_expiry [POOL_SIZE];
  logic [ADDR_W-1:0]  clock_seconds = '0;

  lease_result_t pending_results [$];
  plan_row_t     plan_rows [$];
  lease_result_t seen_want;
  logic [MAC_W-1:0] mac_set [4];
  int  error_count = 0;
  int  items_sent = 0;
  int  stall_left = 0;
  bit  idle_en = 1'b1;
  bit  quiet = 1'b0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  bit  offer_valid = 1'b0;
  logic [ADDR_W-1:0] last_offer = '0;

  address_lease_pool_top i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .address_i        (address_i),
    .client_mac_i     (client_mac_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .result_address_o (result_address_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [MAC_W-1:0] got,
                                 input logic [MAC_W-1:0] want);
    $display("mismatch at %0t: %s, got %h, expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic predict_lease_result(input lease_item_t it, output lease_result_t res);
    logic [ADDR_W-1:0] idx;
    logic [ADDR_W-1:0] srv;
    logic [ADDR_W-1:0] left;
    int unsigned live;
    res.status = STAT_DONE;
    res.addr = '0;
    live = (count_reg > COUNT_W'(POOL_SIZE)) ? POOL_SIZE : int'(count_reg);
    idx = it.addr - base_reg - 32'd1;
    srv = server_reg - base_reg - 32'd1;
    case (it.act)
      ACT_DISCOVER: begin
        res.status = STAT_FULL;
        for (int i = 0; i < live; i++) begin
          if (!slot_used[i] && ADDR_W'(i) != srv) begin
            res.status = STAT_OK;
            res.addr = base_reg + 32'd1 + ADDR_W'(i);
            break;
          end
        end
      end
      ACT_REQUEST: begin
        res.status = STAT_REFUSED;
        if (idx < live && idx != srv) begin
          if (!slot_used[idx[IDX_W-1:0]] || slot_mac[idx[IDX_W-1:0]] == it.mac) begin
            slot_used[idx[IDX_W-1:0]] = 1'b1;
            slot_mac[idx[IDX_W-1:0]] = it.mac;
            slot_expiry[idx[IDX_W-1:0]] = clock_seconds + {1'b0, lease_reg};
            res.status = STAT_OK;
            res.addr = it.addr;
          end
        end
      end
      ACT_RELEASE: begin
        if (idx < live && idx != srv) slot_used[idx[IDX_W-1:0]] = 1'b0;
      end
      default: begin
        clock_seconds = clock_seconds + 32'd1;
        for (int i = 0; i < POOL_SIZE; i++) begin
          if (slot_used[i]) begin
            left = slot_expiry[i] - clock_seconds;
            if (left == '0 || left[ADDR_W-1]) slot_used[i] = 1'b0;
          end
        end
      end
    endcase
  endtask

  task automatic send_item(input lease_item_t it, input bit typed, input lease_result_t want);
    lease_result_t res;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    action_i = it.act;
    address_i = it.addr;
    client_mac_i = it.mac;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    predict_lease_result(it, res);
    if (it.act == ACT_DISCOVER && res.status == STAT_OK) begin
      offer_valid = 1'b1;
      last_offer = res.addr;
    end
    pending_results.push_back(typed ? want : res);
  endtask

  task automatic sender_gap();
    int n;
    if (idle_en && !quiet && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 7);
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_POOL_BASE:      base_reg = data;
      CFG_POOL_COUNT:     count_reg = data[COUNT_W-1:0];
      CFG_SERVER_ADDRESS: server_reg = data;
      default:            lease_reg = data[LEASE_W-1:0];
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic void add_cfg(input cfg_idx_e idx, input logic [31:0] data);
    plan_row_t row;
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.reg_data = data;
    row.item = '0;
    row.typed = 1'b0;
    row.want = '0;
    plan_rows.push_back(row);
  endfunction

  function automatic void add_item(input action_e act, input logic [ADDR_W-1:0] addr,
                                   input logic [MAC_W-1:0] mac, input bit typed,
                                   input status_e st, input logic [ADDR_W-1:0] res);
    plan_row_t row;
    row.is_cfg = 1'b0;
    row.reg_idx = CFG_POOL_BASE;
    row.reg_data = '0;
    row.item.act = act;
    row.item.addr = addr;
    row.item.mac = mac;
    row.typed = typed;
    row.want.status = st;
    row.want.addr = res;
    plan_rows.push_back(row);
  endfunction

  function automatic logic [ADDR_W-1:0] pick_address();
    int unsigned live;
    int unsigned r;
    live = (count_reg > COUNT_W'(POOL_SIZE)) ? POOL_SIZE : int'(count_reg);
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom;
    if (r == 1) return server_reg;
    return base_reg + 32'd1 + ADDR_W'($urandom_range(0, live + 1));
  endfunction

  function automatic logic [MAC_W-1:0] pick_mac();
    if ($urandom_range(0, 9) == 0) return MAC_W'({$urandom, $urandom});
    return mac_set[$urandom_range(0, 3)];
  endfunction

  function automatic lease_item_t random_item();
    lease_item_t it;
    int unsigned r;
    it.act = ACT_TICK;
    it.addr = $urandom;
    it.mac = MAC_W'({$urandom, $urandom});
    r = $urandom_range(0, 99);
    if (offer_valid && $urandom_range(0, 1) == 0) begin
      it.act = ACT_REQUEST;
      it.addr = last_offer;
      it.mac = pick_mac();
      offer_valid = 1'b0;
    end else if (r < 20) begin
      it.act = ACT_DISCOVER;
    end else if (r < 55) begin
      it.act = ACT_REQUEST;
      it.addr = pick_address();
      it.mac = pick_mac();
    end else if (r < 75) begin
      it.act = ACT_RELEASE;
      it.addr = pick_address();
    end else if (r >= 90) begin
      it.act = action_e'($urandom_range(0, 3));
    end
    return it;
  endfunction

  task automatic configure_phase();
    logic [ADDR_W-1:0] base;
    logic [COUNT_W-1:0] cnt;
    logic [ADDR_W-1:0] srv;
    logic [LEASE_W-1:0] lease;
    case ($urandom_range(0, 3))
      0:       base = '0;
      1:       base = '1;
      2:       base = 32'hFFFF_FFFF - $urandom_range(0, 8);
      default: base = $urandom;
    endcase
    case ($urandom_range(0, 9))
      0:       cnt = '0;
      1:       cnt = COUNT_W'(POOL_SIZE);
      2:       cnt = COUNT_W'($urandom_range(257, 511));
      3:       cnt = COUNT_W'($urandom_range(13, 255));
      default: cnt = COUNT_W'($urandom_range(1, 12));
    endcase
    case ($urandom_range(0, 3))
      0:       srv = base + 32'd1 + ADDR_W'($urandom_range(0, int'(cnt)));
      1:       srv = base;
      2:       srv = $urandom;
      default: srv = base + 32'd1;
    endcase
    case ($urandom_range(0, 9))
      0:       lease = '0;
      1:       lease = '1;
      2:       lease = LEASE_W'($urandom);
      default: lease = LEASE_W'($urandom_range(1, 25));
    endcase
    wait_drained();
    write_reg(CFG_POOL_BASE, base);
    write_reg(CFG_POOL_COUNT, ($urandom & ~32'h1FF) | 32'(cnt));
    write_reg(CFG_SERVER_ADDRESS, srv);
    write_reg(CFG_LEASE_SECONDS, {1'($urandom_range(0, 1)), lease});
  endtask

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else if (stall_left > 0) begin
        out_stall_i = 1'b1;
        stall_left--;
      end else if (idle_en && !quiet && $urandom_range(0, 5) == 0) begin
        out_stall_i = 1'b1;
        stall_left = $urandom_range(0, 6);
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no transaction pending", MAC_W'(status_o),
                        MAC_W'(result_address_o));
      end else begin
        seen_want = pending_results.pop_front();
        if (status_o !== seen_want.status)
          report_mismatch("status", MAC_W'(status_o), MAC_W'(seen_want.status));
        if (result_address_o !== seen_want.addr)
          report_mismatch("result_address", MAC_W'(result_address_o),
                          MAC_W'(seen_want.addr));
      end
    end
  end

  initial begin
    lease_item_t it;
    lease_result_t none;
    int phase_len;
    int w;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_POOL_BASE;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    action_i = ACT_DISCOVER;
    address_i = '0;
    client_mac_i = '0;
    none = '0;
    mac_set[0] = '0;
    mac_set[1] = MAC_ALL1;
    mac_set[2] = MAC_W'({$urandom, $urandom});
    mac_set[3] = MAC_W'({$urandom, $urandom});
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    add_item(ACT_DISCOVER, 32'h0, 48'h0, 1'b1, STAT_OK, 32'd1);
    add_item(ACT_REQUEST, 32'd1, 48'h0, 1'b1, STAT_OK, 32'd1);
    add_item(ACT_REQUEST, 32'd1, MAC_ALL1, 1'b1, STAT_REFUSED, 32'd0);
    add_item(ACT_REQUEST, 32'd1, 48'h0, 1'b1, STAT_OK, 32'd1);
    add_item(ACT_DISCOVER, 32'hFFFF_FFFF, MAC_ALL1, 1'b1, STAT_OK, 32'd2);
    add_item(ACT_REQUEST, 32'd0, 48'h0, 1'b1, STAT_REFUSED, 32'd0);
    add_item(ACT_REQUEST, 32'hFFFF_FFFF, MAC_ALL1, 1'b1, STAT_REFUSED, 32'd0);
    add_item(ACT_REQUEST, 32'd256, MAC_ALL1, 1'b1, STAT_OK, 32'd256);
    add_item(ACT_REQUEST, 32'd257, 48'h0, 1'b1, STAT_REFUSED, 32'd0);
    add_item(ACT_RELEASE, 32'd257, 48'h0, 1'b1, STAT_DONE, 32'd0);
    add_item(ACT_RELEASE, 32'd1, MAC_ALL1, 1'b1, STAT_DONE, 32'd0);
    add_item(ACT_RELEASE, 32'd1, 48'h0, 1'b1, STAT_DONE, 32'd0);
    add_item(ACT_TICK, 32'hFFFF_FFFF, MAC_ALL1, 1'b1, STAT_DONE, 32'd0);
    add_cfg(CFG_LEASE_SECONDS, 32'h0);
    add_item(ACT_REQUEST, 32'd3, 48'h0000_5555_AAAA, 1'b0, STAT_OK, 32'd0);
    add_item(ACT_TICK, 32'h0, 48'h0, 1'b1, STAT_DONE, 32'd0);
    add_item(ACT_REQUEST, 32'd3, 48'hAAAA_5555_0000, 1'b0, STAT_OK, 32'd0);
    add_cfg(CFG_SERVER_ADDRESS, 32'd1);
    add_item(ACT_DISCOVER, 32'h0, 48'h0, 1'b0, STAT_OK, 32'd0);
    add_item(ACT_REQUEST, 32'd1, 48'h0, 1'b1, STAT_REFUSED, 32'd0);
    add_item(ACT_RELEASE, 32'd1, 48'h0, 1'b1, STAT_DONE, 32'd0);
    add_cfg(CFG_POOL_COUNT, 32'h0);
    add_item(ACT_DISCOVER, 32'h0, 48'h0, 1'b1, STAT_FULL, 32'd0);
    add_item(ACT_REQUEST, 32'd2, 48'h0, 1'b1, STAT_REFUSED, 32'd0);
    add_cfg(CFG_POOL_COUNT, 32'hFFFF_FFFF);
    add_item(ACT_REQUEST, 32'd256, 48'h0, 1'b0, STAT_OK, 32'd0);
    add_cfg(CFG_POOL_BASE, 32'hFFFF_FFFF);
    add_cfg(CFG_POOL_COUNT, 32'd2);
    add_cfg(CFG_LEASE_SECONDS, 32'h7FFF_FFFF);
    add_item(ACT_REQUEST, 32'd0, MAC_ALL1, 1'b0, STAT_OK, 32'd0);
    add_item(ACT_DISCOVER, 32'h0, 48'h0, 1'b0, STAT_OK, 32'd0);

    foreach (plan_rows[r]) begin
      if (plan_rows[r].is_cfg) begin
        wait_drained();
        write_reg(plan_rows[r].reg_idx, plan_rows[r].reg_data);
      end else begin
        send_item(plan_rows[r].item, plan_rows[r].typed, plan_rows[r].want);
        sender_gap();
      end
    end

    while (items_sent < ITEM_TOTAL) begin
      configure_phase();
      offer_valid = 1'b0;
      idle_en = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(30, 110);
      for (int k = 0; k < phase_len && items_sent < ITEM_TOTAL; k++) begin
        quiet = (items_sent >= ITEM_TOTAL - QUIET_ITEMS);
        if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
          hold_done = 1'b1;
          hold_req = 1'b1;
        end
        it = random_item();
        send_item(it, 1'b0, none);
        sender_gap();
      end
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    w = 0;
    while (pending_results.size() != 0 && w < 5000) begin
      @(posedge clk_i);
      w++;
    end
    if (pending_results.size() != 0)
      report_mismatch("transactions still pending", MAC_W'(pending_results.size()),
                      MAC_W'(0));
    repeat (300) @(posedge clk_i);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
